[src/scld_pkg.sv]
// Shared constants, types and helpers for the serial command line decoder.
package scld_pkg;

    localparam int LINE_CAPACITY  = 64;
    localparam int FIELD_CAPACITY = 16;
    localparam int ARG_SLOTS      = 4;

    localparam int ADDR_W = $clog2(LINE_CAPACITY);
    localparam int NCNT_W = $clog2(FIELD_CAPACITY + 1);
    localparam int FCNT_W = $clog2(FIELD_CAPACITY);
    localparam int ACNT_W = $clog2(ARG_SLOTS + 1);

    localparam int APB_ADDR_W = 3;
    localparam logic REG_SPEED_LIMIT = 1'b0;
    localparam logic REG_POS_LIMIT   = 1'b1;
    localparam logic [15:0] SPEED_LIMIT_RST = 16'd1000;
    localparam logic [15:0] POS_LIMIT_RST   = 16'd10000;
    localparam logic signed [31:0] PWM_DUTY_DEFAULT = 32'sd50;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNKNOWN  = 3'd1;
    localparam logic [2:0] ST_MISSING  = 3'd2;
    localparam logic [2:0] ST_INVALID  = 3'd3;
    localparam logic [2:0] ST_TOO_MANY = 3'd4;
    localparam logic [2:0] ST_TOO_LONG = 3'd5;

    localparam logic [2:0] CMD_NONE = 3'd0;
    localparam logic [2:0] CMD_SPD  = 3'd1;
    localparam logic [2:0] CMD_POS  = 3'd2;
    localparam logic [2:0] CMD_MOVE = 3'd3;
    localparam logic [2:0] CMD_MUL  = 3'd4;
    localparam logic [2:0] CMD_PWM  = 3'd5;
    localparam logic [2:0] CMD_STOP = 3'd6;
    localparam logic [2:0] CMD_HELP = 3'd7;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] PRINT_MIN = 8'h20;

    localparam logic [1:0] CPH_SPACE = 2'd0;
    localparam logic [1:0] CPH_DIGIT = 2'd1;
    localparam logic [1:0] CPH_DONE  = 2'd2;

    localparam int NUM_NAMES = 7;
    localparam logic [2:0] NAME_LEN [NUM_NAMES] = '{3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd4, 3'd4};
    localparam logic [7:0] NAME_CHARS [NUM_NAMES][4] = '{
        '{"S", "P", "D", 8'h00},
        '{"P", "O", "S", 8'h00},
        '{"M", "O", "V", "E"},
        '{"M", "U", "L", 8'h00},
        '{"P", "W", "M", 8'h00},
        '{"S", "T", "O", "P"},
        '{"H", "E", "L", "P"}
    };

    typedef struct packed {
        logic clear;
        logic step;
        logic close;
        logic mult;
        logic done;
        logic ovf;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_stat;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

[src/scld_intf.sv]
// Channel interfaces: received byte words and decoded result words.
interface scld_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface scld_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [2:0]         command_code;
    logic [1:0]         arg_num;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic signed [31:0] third_value;
    logic signed [63:0] reply_value;
    logic               move_request;

    modport source (output valid, output status, output command_code, output arg_num,
                    output first_value, output second_value, output third_value,
                    output reply_value, output move_request, input ready);
    modport sink (input valid, input status, input command_code, input arg_num,
                  input first_value, input second_value, input third_value,
                  input reply_value, input move_request, output ready);
endinterface

[src/scld_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module scld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

[src/scld_ctrl.sv]
// Controller: byte intake, line buffering and the walk over a finished line.
module scld_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rx_valid,
    input  logic [7:0]                 i_rx_byte,
    output logic                       o_rx_ready,
    output logic                       o_wr_en,
    output logic [scld_pkg::ADDR_W-1:0] o_wr_addr,
    output logic [scld_pkg::ADDR_W-1:0] o_rd_addr,
    output scld_pkg::t_cmd             o_cmd,
    input  scld_pkg::t_stat            i_stat
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_CLOSE = 6'b001000,
        S_MULT  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [scld_pkg::ADDR_W-1:0] r_len, n_len;
    logic [scld_pkg::ADDR_W-1:0] r_walk_len, n_walk_len;
    logic [scld_pkg::ADDR_W-1:0] r_idx, n_idx;
    logic r_cr, n_cr;
    logic r_pend, n_pend;

    logic is_lf, is_cr, is_ctl, full, gen, accept;

    always_comb begin
        is_lf  = i_rx_byte == scld_pkg::CH_LF;
        is_cr  = i_rx_byte == scld_pkg::CH_CR;
        is_ctl = i_rx_byte < scld_pkg::PRINT_MIN;
        full   = r_len >= scld_pkg::ADDR_W'(scld_pkg::LINE_CAPACITY - 1);
        gen    = (is_lf && !r_cr && r_len != '0) || (is_cr && r_len != '0)
                 || (!is_ctl && full);
        o_rx_ready = (r_state == S_IDLE) && !(gen && i_stat.out_busy);
        accept = i_rx_valid && o_rx_ready;

        n_state    = r_state;
        n_len      = r_len;
        n_walk_len = r_walk_len;
        n_idx      = r_idx;
        n_cr       = r_cr;
        n_pend     = 1'b0;
        o_cmd      = '0;
        o_cmd.step = r_pend;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_len;
        o_rd_addr  = r_idx;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (is_lf || is_cr) begin
                        n_cr = is_cr;
                        if ((is_cr || !r_cr) && r_len != '0) begin
                            n_walk_len  = r_len;
                            n_len       = '0;
                            n_idx       = '0;
                            o_cmd.clear = 1'b1;
                            n_state     = S_READ;
                        end
                    end else begin
                        n_cr = 1'b0;
                        if (!is_ctl) begin
                            if (full) begin
                                n_len     = '0;
                                o_cmd.ovf = 1'b1;
                            end else begin
                                o_wr_en = 1'b1;
                                n_len   = r_len + 1'b1;
                            end
                        end
                    end
                end
            end
            S_READ: begin
                n_pend = 1'b1;
                if (r_idx == r_walk_len - 1'b1) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: n_state = S_CLOSE;
            S_CLOSE: begin
                o_cmd.close = 1'b1;
                n_state     = S_MULT;
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                o_cmd.done = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_cr    <= 1'b0;
            r_pend  <= 1'b0;
            r_idx   <= '0;
            r_walk_len <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_cr    <= n_cr;
            r_pend  <= n_pend;
            r_idx   <= n_idx;
            r_walk_len <= n_walk_len;
        end
    end

`ifndef SYNTHESIS
    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_walk_len != '0))
        else $error("line walk started on an empty line");
    a_step_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> $past(r_state == S_READ))
        else $error("byte step without a read");
    a_ovf_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ovf |-> !i_stat.out_busy)
        else $error("overflow result while output busy");
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.done |-> !i_stat.out_busy)
        else $error("decode result while output busy");
`endif
endmodule

[src/scld_dp.sv]
// Datapath: streaming name match, argument conversion, execution and result word.
module scld_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  scld_pkg::t_cmd  i_cmd,
    output scld_pkg::t_stat o_stat,
    input  logic [7:0]      i_char,
    input  logic [15:0]     i_speed_limit,
    input  logic [15:0]     i_pos_limit,
    scld_res_if.source      o_res
);
    logic                              r_in_args, n_in_args;
    logic [scld_pkg::NCNT_W-1:0]       r_name_cnt, n_name_cnt;
    logic [scld_pkg::NUM_NAMES-1:0]    r_match, n_match;
    logic                              r_stop, n_stop;
    logic                              r_fnon, n_fnon;
    logic [scld_pkg::FCNT_W-1:0]       r_fchars, n_fchars;
    logic [1:0]                        r_cph, n_cph;
    logic                              r_neg, n_neg;
    logic [31:0]                       r_acc, n_acc;
    logic [scld_pkg::ACNT_W-1:0]       r_cnt, n_cnt;
    logic signed [31:0]                r_val [3];
    logic signed [31:0]                n_val [3];
    logic signed [63:0]                r_prod;
    logic [15:0]                       r_speed, n_speed;
    logic signed [16:0]                r_pos, n_pos;

    logic                              r_valid, n_valid;
    logic [2:0]                        r_status, n_status;
    logic [2:0]                        r_code, n_code;
    logic [1:0]                        r_acnt, n_acnt;
    logic signed [31:0]                r_v0, n_v0, r_v1, n_v1, r_v2, n_v2;
    logic signed [63:0]                r_reply, n_reply;
    logic                              r_mv, n_mv;

    logic [7:0]  up;
    logic        is_digit;
    logic [3:0]  digit;
    logic [35:0] wide;
    logic [31:0] acc_step;
    logic signed [31:0] fval;
    logic        do_close;
    logic [scld_pkg::NCNT_W-1:0] nlen;
    logic [2:0]  code;
    logic        long_name;
    logic [2:0]  st;
    logic signed [31:0] lim_s, pos_lim_s;

    always_comb begin
        up       = scld_pkg::to_upper(i_char);
        is_digit = i_char inside {[scld_pkg::CH_0:scld_pkg::CH_9]};
        digit    = 4'(i_char - scld_pkg::CH_0);
        wide     = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {32'b0, digit};
        acc_step = (wide > 36'h080000000) ? 32'h80000000 : wide[31:0];
        if (r_neg) begin
            fval = -$signed(r_acc);
        end else begin
            fval = (r_acc > 32'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(r_acc);
        end

        n_in_args  = r_in_args;
        n_name_cnt = r_name_cnt;
        n_match    = r_match;
        n_stop     = r_stop;
        n_fnon     = r_fnon;
        n_fchars   = r_fchars;
        n_cph      = r_cph;
        n_neg      = r_neg;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_val      = r_val;
        do_close   = 1'b0;

        if (i_cmd.step) begin
            if (!r_in_args) begin
                if (i_char == scld_pkg::CH_EQ) begin
                    n_in_args = 1'b1;
                end else begin
                    for (int k = 0; k < scld_pkg::NUM_NAMES; k++) begin
                        if (r_name_cnt < scld_pkg::NCNT_W'(scld_pkg::NAME_LEN[k]) &&
                            up != scld_pkg::NAME_CHARS[k][r_name_cnt[1:0]]) begin
                            n_match[k] = 1'b0;
                        end
                    end
                    if (r_name_cnt < scld_pkg::NCNT_W'(scld_pkg::FIELD_CAPACITY)) begin
                        n_name_cnt = r_name_cnt + 1'b1;
                    end
                end
            end else if (!r_stop) begin
                if (i_char == scld_pkg::CH_COMMA) begin
                    do_close = 1'b1;
                end else begin
                    n_fnon = 1'b1;
                    if (r_fchars < scld_pkg::FCNT_W'(scld_pkg::FIELD_CAPACITY - 1)) begin
                        n_fchars = r_fchars + 1'b1;
                        case (r_cph)
                            scld_pkg::CPH_SPACE: begin
                                if (i_char == scld_pkg::CH_SPACE) begin
                                    n_cph = scld_pkg::CPH_SPACE;
                                end else if (i_char inside {scld_pkg::CH_PLUS,
                                                            scld_pkg::CH_MINUS}) begin
                                    n_neg = i_char == scld_pkg::CH_MINUS;
                                    n_cph = scld_pkg::CPH_DIGIT;
                                end else if (is_digit) begin
                                    n_acc = {28'b0, digit};
                                    n_cph = scld_pkg::CPH_DIGIT;
                                end else begin
                                    n_cph = scld_pkg::CPH_DONE;
                                end
                            end
                            scld_pkg::CPH_DIGIT: begin
                                if (is_digit) begin
                                    n_acc = acc_step;
                                end else begin
                                    n_cph = scld_pkg::CPH_DONE;
                                end
                            end
                            default: n_cph = scld_pkg::CPH_DONE;
                        endcase
                    end
                end
            end
        end
        if (i_cmd.close && r_in_args && !r_stop) begin
            do_close = 1'b1;
        end
        if (do_close) begin
            if (r_fnon) begin
                if (r_cnt < scld_pkg::ACNT_W'(3)) begin
                    n_val[r_cnt[1:0]] = fval;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt + 1'b1 >= scld_pkg::ACNT_W'(scld_pkg::ARG_SLOTS)) begin
                    n_stop = 1'b1;
                end
            end
            n_fnon   = 1'b0;
            n_fchars = '0;
            n_cph    = scld_pkg::CPH_SPACE;
            n_neg    = 1'b0;
            n_acc    = '0;
        end
        if (i_cmd.clear) begin
            n_in_args  = 1'b0;
            n_name_cnt = '0;
            n_match    = '1;
            n_stop     = 1'b0;
            n_fnon     = 1'b0;
            n_fchars   = '0;
            n_cph      = scld_pkg::CPH_SPACE;
            n_neg      = 1'b0;
            n_acc      = '0;
            n_cnt      = '0;
            for (int j = 0; j < 3; j++) begin
                n_val[j] = '0;
            end
        end
    end

    // Execution of the decoded line.
    always_comb begin
        nlen = r_in_args ? r_name_cnt :
               ((r_name_cnt < scld_pkg::NCNT_W'(scld_pkg::FIELD_CAPACITY - 1)) ? r_name_cnt :
                scld_pkg::NCNT_W'(scld_pkg::FIELD_CAPACITY - 1));
        long_name = r_in_args && r_name_cnt >= scld_pkg::NCNT_W'(scld_pkg::FIELD_CAPACITY);
        code = scld_pkg::CMD_NONE;
        for (int k = scld_pkg::NUM_NAMES - 1; k >= 0; k--) begin
            if (r_match[k] && scld_pkg::NCNT_W'(scld_pkg::NAME_LEN[k]) == nlen) begin
                code = 3'(k + 1);
            end
        end
        lim_s     = $signed({16'b0, i_speed_limit});
        pos_lim_s = $signed({16'b0, i_pos_limit});

        n_valid  = r_valid && !o_res.ready;
        n_status = r_status;
        n_code   = r_code;
        n_acnt   = r_acnt;
        n_v0     = r_v0;
        n_v1     = r_v1;
        n_v2     = r_v2;
        n_reply  = r_reply;
        n_mv     = r_mv;
        n_speed  = r_speed;
        n_pos    = r_pos;
        st       = scld_pkg::ST_OK;

        if (i_cmd.ovf) begin
            n_valid  = 1'b1;
            n_status = scld_pkg::ST_TOO_LONG;
            n_code   = scld_pkg::CMD_NONE;
            n_acnt   = '0;
            n_v0     = '0;
            n_v1     = '0;
            n_v2     = '0;
            n_reply  = '0;
            n_mv     = 1'b0;
        end else if (i_cmd.done) begin
            n_valid = 1'b1;
            n_v0    = r_val[0];
            n_v1    = r_val[1];
            n_v2    = r_val[2];
            n_reply = '0;
            n_mv    = 1'b0;
            n_code  = code;
            n_acnt  = (r_cnt > scld_pkg::ACNT_W'(3)) ? 2'd3 : r_cnt[1:0];
            if (long_name) begin
                st     = scld_pkg::ST_UNKNOWN;
                n_code = scld_pkg::CMD_NONE;
                n_acnt = '0;
                n_v0   = '0;
                n_v1   = '0;
                n_v2   = '0;
            end else if (r_stop) begin
                st = scld_pkg::ST_TOO_MANY;
            end else begin
                case (code)
                    scld_pkg::CMD_SPD: begin
                        if (r_cnt == '0) begin
                            n_reply = {48'b0, r_speed};
                        end else if (r_cnt == scld_pkg::ACNT_W'(1) && r_val[0] >= 0 &&
                                     r_val[0] <= lim_s) begin
                            n_speed = r_val[0][15:0];
                            n_reply = 64'(r_val[0]);
                        end else begin
                            st = scld_pkg::ST_INVALID;
                        end
                    end
                    scld_pkg::CMD_POS: begin
                        if (r_cnt == '0) begin
                            n_reply = 64'(r_pos);
                        end else if (r_cnt == scld_pkg::ACNT_W'(1) && r_val[0] >= -pos_lim_s &&
                                     r_val[0] <= pos_lim_s) begin
                            n_pos   = r_val[0][16:0];
                            n_reply = 64'(r_val[0]);
                        end else begin
                            st = scld_pkg::ST_INVALID;
                        end
                    end
                    scld_pkg::CMD_MOVE: begin
                        if (r_cnt == '0) begin
                            st = scld_pkg::ST_MISSING;
                        end else if (r_cnt == scld_pkg::ACNT_W'(3)) begin
                            n_v0 = {24'b0, r_val[0][7:0]};
                            n_mv = 1'b1;
                        end
                    end
                    scld_pkg::CMD_MUL: begin
                        if (r_cnt != scld_pkg::ACNT_W'(2)) begin
                            st = scld_pkg::ST_INVALID;
                        end else begin
                            n_reply = r_prod;
                        end
                    end
                    scld_pkg::CMD_PWM: begin
                        if (r_cnt < scld_pkg::ACNT_W'(2)) begin
                            st = scld_pkg::ST_MISSING;
                        end else if (r_cnt == scld_pkg::ACNT_W'(2)) begin
                            n_v2 = scld_pkg::PWM_DUTY_DEFAULT;
                        end
                    end
                    scld_pkg::CMD_STOP, scld_pkg::CMD_HELP: st = scld_pkg::ST_OK;
                    default: st = scld_pkg::ST_UNKNOWN;
                endcase
            end
            n_status = st;
            if (st != scld_pkg::ST_OK) begin
                n_reply = '0;
                n_mv    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_speed <= '0;
            r_pos   <= '0;
        end else begin
            r_valid <= n_valid;
            r_speed <= n_speed;
            r_pos   <= n_pos;
        end
        r_in_args  <= n_in_args;
        r_name_cnt <= n_name_cnt;
        r_match    <= n_match;
        r_stop     <= n_stop;
        r_fnon     <= n_fnon;
        r_fchars   <= n_fchars;
        r_cph      <= n_cph;
        r_neg      <= n_neg;
        r_acc      <= n_acc;
        r_cnt      <= n_cnt;
        r_val      <= n_val;
        // 32 x 32 signed product, sign-extended operands
        if (i_cmd.mult) begin
            r_prod <= 64'(r_val[0]) * 64'(r_val[1]);
        end
        r_status <= n_status;
        r_code   <= n_code;
        r_acnt   <= n_acnt;
        r_v0     <= n_v0;
        r_v1     <= n_v1;
        r_v2     <= n_v2;
        r_reply  <= n_reply;
        r_mv     <= n_mv;
    end

    assign o_stat.out_busy     = r_valid;
    assign o_res.valid         = r_valid;
    assign o_res.status        = r_status;
    assign o_res.command_code  = r_code;
    assign o_res.arg_num       = r_acnt;
    assign o_res.first_value   = r_v0;
    assign o_res.second_value  = r_v1;
    assign o_res.third_value   = r_v2;
    assign o_res.reply_value   = r_reply;
    assign o_res.move_request  = r_mv;
endmodule

[src/serial_command_line_decoder_top.sv]
// Top level of the serial command line decoder.
// Usage:
//   i_rx carries received byte words (valid/ready). CR, LF or CR LF ends a line;
//   other control bytes are dropped. Printable bytes go into a 64-entry line RAM.
//   o_res gives one result word per completed non-empty line, and one with
//   status "line too long" when a byte arrives at a full line.
//   Limits for SPD and POS are set over the APB port (0x0 speed, 0x4 position).
// Timing:
//   A line end walks the line RAM, one byte per cycle through its registered
//   read port, then runs the drain, last field, multiply and execute steps.
//   No byte is taken during the walk and these steps. The result sits in an
//   output register.
// Reset:
//   Synchronous, active low; clears line length, CR mark, speed and position.
// Stall:
//   While a result waits, ordinary bytes are still taken; a byte that would
//   produce another result is held off until the waiting word is taken.
module serial_command_line_decoder_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    scld_rx_if.sink                          i_rx,
    scld_res_if.source                       o_res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [scld_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    logic [15:0] r_speed_lim, r_pos_lim;
    logic        wr_en;
    logic [scld_pkg::ADDR_W-1:0] wr_addr, rd_addr;
    logic [7:0]  rd_data;
    scld_pkg::t_cmd  cmd;
    scld_pkg::t_stat stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_lim <= scld_pkg::SPEED_LIMIT_RST;
            r_pos_lim   <= scld_pkg::POS_LIMIT_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == scld_pkg::REG_SPEED_LIMIT) begin
                r_speed_lim <= pwdata[15:0];
            end else begin
                r_pos_lim <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == scld_pkg::REG_SPEED_LIMIT) ? {16'b0, r_speed_lim}
                                                            : {16'b0, r_pos_lim};

    scld_ram #(
        .WIDTH (8),
        .DEPTH (scld_pkg::LINE_CAPACITY)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_rx.rx_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    scld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx.valid),
        .i_rx_byte  (i_rx.rx_byte),
        .o_rx_ready (i_rx.ready),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_rd_addr  (rd_addr),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    scld_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_char        (rd_data),
        .i_speed_limit (r_speed_lim),
        .i_pos_limit   (r_pos_lim),
        .o_res         (o_res)
    );
endmodule
